[src/kic_pkg.sv]
// Shared types, constants and codes of the k-gram candidate index block.
`timescale 1ns / 1ps

package kic_pkg;

    // Defaults for the top level parameters.
    localparam int MAX_GRAM_DEF    = 8;
    localparam int MAX_IDS_DEF     = 64;
    localparam int TABLE_DEPTH_DEF = 256;

    // Fixed field widths.
    localparam int CFG_W    = 4;
    localparam int ID_W     = 7;
    localparam int BITMAP_W = 64;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic [CFG_W-1:0] GRAM_LEN_RESET = 4'd3;

    // Register index taken from the word address.
    localparam logic REG_GRAM_LENGTH = 1'b0;

    // Input commands.
    localparam logic [1:0] CMD_INDEX  = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Result kinds.
    localparam logic KIND_INDEX = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } t_kic_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;   // wipe counters, window and flags
        logic load;    // take a character transaction
        logic search;  // step the table scan
        logic apply;   // update the table or the union with the scan outcome
        logic emit;    // load the result register
    } t_kic_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_clear;
        logic item_skip;
        logic item_search;
        logic item_ends;
        logic search_done;
        logic out_free;
    } t_kic_sts;

endpackage

[src/kic_ctrl.sv]
// Controller state machine of the k-gram candidate index block.
`timescale 1ns / 1ps

module kic_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  kic_pkg::t_kic_sts i_sts,
    output kic_pkg::t_kic_cmd o_cmd,
    output logic              o_in_stall
);

    kic_pkg::t_kic_state r_state, n_state;
    logic                r_ends, n_ends;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kic_pkg::ST_IDLE;
            r_ends  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ends  <= n_ends;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ends     = r_ends;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            kic_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_sts.item_clear) begin
                        o_cmd.clear = 1'b1;
                    end else if (!i_sts.item_skip) begin
                        o_cmd.load = 1'b1;
                        n_ends     = i_sts.item_ends;
                        if (i_sts.item_search) begin
                            n_state = kic_pkg::ST_SEARCH;
                        end else if (i_sts.item_ends) begin
                            n_state = kic_pkg::ST_EMIT;
                        end
                    end
                end
            end
            kic_pkg::ST_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_sts.search_done) begin
                    o_cmd.apply = 1'b1;
                    n_state     = r_ends ? kic_pkg::ST_EMIT : kic_pkg::ST_IDLE;
                end
            end
            kic_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = kic_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kic_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[src/kic_dp.sv]
// Datapath of the k-gram candidate index: window, gram table, counters and result register.
`timescale 1ns / 1ps

module kic_dp #(
    parameter int MAX_GRAM    = kic_pkg::MAX_GRAM_DEF,
    parameter int MAX_IDS     = kic_pkg::MAX_IDS_DEF,
    parameter int TABLE_DEPTH = kic_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kic_pkg::t_kic_cmd             i_cmd,
    output kic_pkg::t_kic_sts             o_sts,
    input  logic [kic_pkg::CFG_W-1:0]     i_gram_length,
    input  logic [1:0]                    i_command,
    input  logic [7:0]                    i_char_byte,
    input  logic                          i_end_of_string,
    input  logic                          i_empty_string,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic                          o_result_kind,
    output logic [kic_pkg::ID_W-1:0]      o_string_id,
    output logic [kic_pkg::BITMAP_W-1:0]  o_match_bitmap,
    output logic                          o_grams_dropped,
    output logic                          o_ids_exhausted
);

    localparam int WW = 8 * MAX_GRAM;
    localparam int FW = $clog2(MAX_GRAM + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = kic_pkg::ID_W;
    localparam int KW = kic_pkg::CFG_W;

    logic [WW-1:0]      key_mem [TABLE_DEPTH];
    logic [MAX_IDS-1:0] id_mem  [TABLE_DEPTH];

    logic [WW-1:0]      r_window;
    logic [FW-1:0]      r_fill;
    logic [IW-1:0]      r_next_id;
    logic [CW-1:0]      r_count;
    logic [MAX_IDS-1:0] r_union;
    logic               r_drop;
    logic [1:0]         r_cmd;
    logic [CW-1:0]      r_rd_idx;
    logic               r_rd_vld;
    logic [AW-1:0]      r_q_idx;
    logic [WW-1:0]      r_key_q;
    logic [MAX_IDS-1:0] r_ids_q;

    logic               r_out_valid;
    logic               r_out_kind;
    logic [IW-1:0]      r_out_id;
    logic [MAX_IDS-1:0] r_out_bitmap;
    logic               r_out_dropped;
    logic               r_out_exhausted;

    logic [KW-1:0]      k_eff;
    logic [WW-1:0]      key_mask;
    logic [WW-1:0]      key;
    logic [FW-1:0]      fill_inc;
    logic               id_ok;
    logic [MAX_IDS-1:0] id_bit;
    logic [IW-1:0]      nid_inc;
    logic               hit;
    logic               rd_en;
    logic               room;
    logic               key_we;
    logic               id_we;
    logic [AW-1:0]      id_wa;
    logic [MAX_IDS-1:0] id_wd;

    // Out-of-range gram lengths clamp into 1..MAX_GRAM.
    always_comb begin
        if (i_gram_length == '0) begin
            k_eff = KW'(1);
        end else if (i_gram_length > KW'(MAX_GRAM)) begin
            k_eff = KW'(MAX_GRAM);
        end else begin
            k_eff = i_gram_length;
        end
        for (int b = 0; b < MAX_GRAM; b++) begin
            key_mask[b*8 +: 8] = (KW'(b) < k_eff) ? 8'hFF : 8'h00;
        end
    end

    assign key      = r_window & key_mask;
    assign fill_inc = (r_fill < FW'(MAX_GRAM)) ? r_fill + FW'(1) : r_fill;
    assign id_ok    = r_next_id < IW'(MAX_IDS);
    assign id_bit   = MAX_IDS'(1) << r_next_id;
    assign nid_inc  = (r_next_id <= IW'(MAX_IDS)) ? r_next_id + IW'(1) : r_next_id;
    assign hit      = r_rd_vld && (r_key_q == key);
    assign rd_en    = i_cmd.search && (r_rd_idx < r_count) && !hit;
    assign room     = r_count != CW'(TABLE_DEPTH);

    always_comb begin
        o_sts.item_clear  = i_command == kic_pkg::CMD_CLEAR;
        o_sts.item_skip   = i_command == kic_pkg::CMD_UNUSED;
        o_sts.item_search = !i_empty_string && (KW'(fill_inc) >= k_eff)
                            && ((i_command == kic_pkg::CMD_QUERY) || id_ok);
        o_sts.item_ends   = i_end_of_string || i_empty_string;
        o_sts.search_done = hit || (r_rd_idx == r_count);
        o_sts.out_free    = !r_out_valid || !i_out_stall;
    end

    // Table writes: a found key gains the id, a new key takes the next free entry if any.
    always_comb begin
        key_we = 1'b0;
        id_we  = 1'b0;
        id_wa  = r_q_idx;
        id_wd  = r_ids_q | id_bit;
        if (i_cmd.apply && (r_cmd == kic_pkg::CMD_INDEX)) begin
            if (hit) begin
                id_we = 1'b1;
            end else if (room) begin
                key_we = 1'b1;
                id_we  = 1'b1;
                id_wa  = r_count[AW-1:0];
                id_wd  = id_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[r_count[AW-1:0]] <= key;
        end
        if (id_we) begin
            id_mem[id_wa] <= id_wd;
        end
        if (rd_en) begin
            r_key_q <= key_mem[r_rd_idx[AW-1:0]];
            r_ids_q <= id_mem[r_rd_idx[AW-1:0]];
            r_q_idx <= r_rd_idx[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_window  <= '0;
            r_fill    <= '0;
            r_next_id <= '0;
            r_count   <= '0;
            r_union   <= '0;
            r_drop    <= 1'b0;
            r_rd_idx  <= '0;
            r_rd_vld  <= 1'b0;
            r_cmd     <= kic_pkg::CMD_INDEX;
        end else begin
            if (i_cmd.load) begin
                if (!i_empty_string) begin
                    r_window <= (r_window << 8) | WW'(i_char_byte);
                    r_fill   <= fill_inc;
                end
                r_cmd    <= i_command;
                r_rd_idx <= '0;
                r_rd_vld <= 1'b0;
            end
            if (i_cmd.search) begin
                r_rd_vld <= rd_en;
                if (rd_en) begin
                    r_rd_idx <= r_rd_idx + CW'(1);
                end
            end
            if (i_cmd.apply) begin
                if (r_cmd == kic_pkg::CMD_INDEX) begin
                    if (!hit) begin
                        if (room) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_drop <= 1'b1;
                        end
                    end
                end else if (hit) begin
                    r_union <= r_union | r_ids_q;
                end
            end
            if (i_cmd.emit) begin
                r_window <= '0;
                r_fill   <= '0;
                if (r_cmd == kic_pkg::CMD_QUERY) begin
                    r_union <= '0;
                end else begin
                    r_next_id <= nid_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_dropped <= r_drop;
            if (r_cmd == kic_pkg::CMD_QUERY) begin
                r_out_kind      <= kic_pkg::KIND_QUERY;
                r_out_id        <= '0;
                r_out_bitmap    <= r_union;
                r_out_exhausted <= r_next_id > IW'(MAX_IDS);
            end else begin
                r_out_kind      <= kic_pkg::KIND_INDEX;
                r_out_id        <= id_ok ? r_next_id + IW'(1) : '0;
                r_out_bitmap    <= '0;
                r_out_exhausted <= nid_inc > IW'(MAX_IDS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_out_kind;
    assign o_string_id     = r_out_id;
    assign o_match_bitmap  = kic_pkg::BITMAP_W'(r_out_bitmap);
    assign o_grams_dropped = r_out_dropped;
    assign o_ids_exhausted = r_out_exhausted;

endmodule

[src/kgram_index_candidate_match.sv]
// Top level of the k-gram candidate index: configuration port, controller and datapath.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_command, i_char_byte, i_end_of_string,
//                                                i_empty_string
// result    out        o_out_valid / i_out_stall o_result_kind, o_string_id, o_match_bitmap,
//                                                o_grams_dropped, o_ids_exhausted
// config    in         psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// A character transaction that completes a gram stalls the input while the key table is
// scanned through its single read port, until a hit or the last stored entry.
// A transaction that ends a string then loads the result register once it is free.
// Clear and unused commands need no scan; clear resets only registers, so it needs no sweep.
// Reset is synchronous and active low; the table contents are never cleared.
// A waiting result does not block the next input transaction, only the next result.
module kgram_index_candidate_match #(
    parameter int MAX_GRAM    = kic_pkg::MAX_GRAM_DEF,
    parameter int MAX_IDS     = kic_pkg::MAX_IDS_DEF,
    parameter int TABLE_DEPTH = kic_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_command,
    input  logic [7:0]                    i_char_byte,
    input  logic                          i_end_of_string,
    input  logic                          i_empty_string,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_result_kind,
    output logic [kic_pkg::ID_W-1:0]      o_string_id,
    output logic [kic_pkg::BITMAP_W-1:0]  o_match_bitmap,
    output logic                          o_grams_dropped,
    output logic                          o_ids_exhausted,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kic_pkg::APB_AW-1:0]    paddr,
    input  logic [kic_pkg::APB_DW-1:0]    pwdata,
    output logic [kic_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    logic [kic_pkg::CFG_W-1:0] r_gram_length;
    logic                      cfg_write;
    kic_pkg::t_kic_cmd         cmd;
    kic_pkg::t_kic_sts         sts;

    // The port never inserts wait states. Bit 2 of the byte address selects the
    // register word; only word zero holds a register, writes to the other are dropped.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gram_length <= kic_pkg::GRAM_LEN_RESET;
        end else if (cfg_write && (paddr[2] == kic_pkg::REG_GRAM_LENGTH)) begin
            r_gram_length <= pwdata[kic_pkg::CFG_W-1:0];
        end
    end

    // Reads return the raw register value; the datapath applies the clamping.
    assign prdata = (paddr[2] == kic_pkg::REG_GRAM_LENGTH)
                    ? kic_pkg::APB_DW'(r_gram_length) : '0;

    // The controller sequences accept, table scan, update and result load.
    kic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath holds the character window, the key and id memories,
    // the id counter, the query union, the sticky flags and the result register.
    kic_dp #(
        .MAX_GRAM    (MAX_GRAM),
        .MAX_IDS     (MAX_IDS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_gram_length   (r_gram_length),
        .i_command       (i_command),
        .i_char_byte     (i_char_byte),
        .i_end_of_string (i_end_of_string),
        .i_empty_string  (i_empty_string),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_result_kind   (o_result_kind),
        .o_string_id     (o_string_id),
        .o_match_bitmap  (o_match_bitmap),
        .o_grams_dropped (o_grams_dropped),
        .o_ids_exhausted (o_ids_exhausted)
    );

endmodule

[tb/sv/kic_checker.sv]
// Checker for the k-gram candidate index: predicts every result and compares it field by field.
`timescale 1ns / 1ps

module kic_checker #(
    parameter int MAX_GRAM    = kic_pkg::MAX_GRAM_DEF,
    parameter int MAX_IDS     = kic_pkg::MAX_IDS_DEF,
    parameter int TABLE_DEPTH = kic_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [1:0]                    i_command,
    input  logic [7:0]                    i_char_byte,
    input  logic                          i_end_of_string,
    input  logic                          i_empty_string,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_result_kind,
    input  logic [kic_pkg::ID_W-1:0]      i_string_id,
    input  logic [kic_pkg::BITMAP_W-1:0]  i_match_bitmap,
    input  logic                          i_grams_dropped,
    input  logic                          i_ids_exhausted,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [kic_pkg::APB_AW-1:0]    i_paddr,
    input  logic [kic_pkg::APB_DW-1:0]    i_pwdata,
    input  logic                          i_pready,
    output int                            o_error_count,
    output int                            o_outstanding
);

    typedef struct packed {
        logic                         kind;
        logic [kic_pkg::ID_W-1:0]     id;
        logic [kic_pkg::BITMAP_W-1:0] bitmap;
        logic                         dropped;
        logic                         exhausted;
    } t_match_result;

    // Shadow copy of the index state.
    logic [63:0]                  window;
    int unsigned                  fill;
    int unsigned                  ids_used;
    int unsigned                  entries;
    logic [63:0]                  key_tbl [TABLE_DEPTH];
    logic [kic_pkg::BITMAP_W-1:0] members [TABLE_DEPTH];
    logic [kic_pkg::BITMAP_W-1:0] union_acc;
    logic                         drop_seen;
    logic [kic_pkg::CFG_W-1:0]    gram_len;

    t_match_result pending_results [$];
    int            errors = 0;

    task automatic wipe_index();
        window    = '0;
        fill      = 0;
        ids_used  = 0;
        entries   = 0;
        union_acc = '0;
        drop_seen = 1'b0;
    endtask

    // A length of zero behaves as one, anything above the maximum as the maximum.
    function automatic int unsigned active_gram_len();
        if (gram_len == '0) return 1;
        if (int'(gram_len) > MAX_GRAM) return MAX_GRAM;
        return gram_len;
    endfunction

    task automatic absorb_char(input logic [1:0] cmd, input logic [7:0] ch,
                               input logic eos, input logic empty);
        int unsigned   k;
        int unsigned   pos;
        int unsigned   i;
        logic          id_ok;
        logic [63:0]   key;
        logic [63:0]   mask;
        t_match_result res;

        k = active_gram_len();
        if (cmd == kic_pkg::CMD_UNUSED) return;
        if (cmd == kic_pkg::CMD_CLEAR) begin
            wipe_index();
            return;
        end

        id_ok = (ids_used < MAX_IDS);

        if (!empty) begin
            window = {window[55:0], ch};
            if (fill < MAX_GRAM) fill++;
            if (fill >= k) begin
                mask = (k >= 8) ? '1 : ((64'd1 << (8 * k)) - 64'd1);
                key  = window & mask;
                pos  = entries;
                for (i = 0; i < entries && pos == entries; i++) begin
                    if (key_tbl[i] == key) pos = i;
                end
                if (cmd == kic_pkg::CMD_INDEX) begin
                    if (id_ok) begin
                        if (pos < entries) begin
                            members[pos] |= 64'd1 << ids_used;
                        end else if (entries < TABLE_DEPTH) begin
                            key_tbl[entries] = key;
                            members[entries] = 64'd1 << ids_used;
                            entries++;
                        end else begin
                            drop_seen = 1'b1;
                        end
                    end
                end else if (pos < entries) begin
                    union_acc |= members[pos];
                end
            end
        end

        if (!(eos || empty)) return;

        window = '0;
        fill   = 0;
        if (cmd == kic_pkg::CMD_INDEX) begin
            res.kind   = kic_pkg::KIND_INDEX;
            res.id     = id_ok ? kic_pkg::ID_W'(ids_used + 1) : '0;
            res.bitmap = '0;
            if (ids_used <= MAX_IDS) ids_used++;
        end else begin
            res.kind   = kic_pkg::KIND_QUERY;
            res.id     = '0;
            res.bitmap = union_acc;
            union_acc  = '0;
        end
        res.dropped   = drop_seen;
        res.exhausted = (ids_used > MAX_IDS);
        pending_results.insert(pending_results.size(), res);
    endtask

    task automatic check_field(input string what, input logic [kic_pkg::BITMAP_W-1:0] want,
                               input logic [kic_pkg::BITMAP_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_match_result want;
        if (!i_rst_n) begin
            wipe_index();
            gram_len = kic_pkg::GRAM_LEN_RESET;
            pending_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[kic_pkg::APB_AW-1:2] == kic_pkg::REG_GRAM_LENGTH) begin
                gram_len = i_pwdata[kic_pkg::CFG_W-1:0];
            end
            // Results leaving now were predicted earlier, so compare before predicting.
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d id %0d map %0h",
                             $time, i_result_kind, i_string_id, i_match_bitmap);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("result_kind", want.kind, i_result_kind);
                    check_field("string_id", want.id, i_string_id);
                    check_field("match_bitmap", want.bitmap, i_match_bitmap);
                    check_field("grams_dropped", want.dropped, i_grams_dropped);
                    check_field("ids_exhausted", want.exhausted, i_ids_exhausted);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_char(i_command, i_char_byte, i_end_of_string, i_empty_string);
            end
        end
        o_error_count <= errors;
        o_outstanding <= pending_results.size();
    end

endmodule

[tb/sv/testbench.sv]
// Top of the k-gram candidate index testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module testbench;

    // The longest single transaction scans the whole table and then loads the result register,
    // so this many quiet cycles guarantee the block has finished before a register write.
    localparam int SETTLE_CYCLES  = 300;
    // One long receiver hold-off, well below the watchdog limit.
    localparam int HOLD_CYCLES    = 1200;
    localparam int WATCHDOG_LIMIT = 20000;
    // Characters used to overflow the key table with two-character grams.
    localparam int FILL_LEN       = 270;
    localparam int FILL_HALF      = FILL_LEN / 2;
    localparam logic [kic_pkg::APB_AW-1:0] GRAM_LENGTH_ADDR = {kic_pkg::REG_GRAM_LENGTH, 2'b00};

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         in_valid    = 1'b0;
    logic                         in_stall;
    logic [1:0]                   command     = kic_pkg::CMD_INDEX;
    logic [7:0]                   char_byte   = 8'h00;
    logic                         end_of_str  = 1'b0;
    logic                         empty_str   = 1'b0;
    logic                         out_valid;
    logic                         out_stall   = 1'b0;
    logic                         result_kind;
    logic [kic_pkg::ID_W-1:0]     string_id;
    logic [kic_pkg::BITMAP_W-1:0] match_bitmap;
    logic                         grams_dropped;
    logic                         ids_exhausted;
    logic                         psel        = 1'b0;
    logic                         penable     = 1'b0;
    logic                         pwrite      = 1'b0;
    logic [kic_pkg::APB_AW-1:0]   paddr       = '0;
    logic [kic_pkg::APB_DW-1:0]   pwdata      = '0;
    logic [kic_pkg::APB_DW-1:0]   prdata;
    logic                         pready;

    int          error_count;
    int          outstanding;
    int          idle_cycles = 0;
    int unsigned items_sent  = 0;
    // While calm is set neither side idles; hold_off_go starts the single long receiver hold.
    bit          calm        = 1'b0;
    bit          hold_off_go = 1'b0;
    logic [7:0]  fill_chars [FILL_LEN];

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    kgram_index_candidate_match i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_command       (command),
        .i_char_byte     (char_byte),
        .i_end_of_string (end_of_str),
        .i_empty_string  (empty_str),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_result_kind   (result_kind),
        .o_string_id     (string_id),
        .o_match_bitmap  (match_bitmap),
        .o_grams_dropped (grams_dropped),
        .o_ids_exhausted (ids_exhausted),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    kic_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_command       (command),
        .i_char_byte     (char_byte),
        .i_end_of_string (end_of_str),
        .i_empty_string  (empty_str),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_result_kind   (result_kind),
        .i_string_id     (string_id),
        .i_match_bitmap  (match_bitmap),
        .i_grams_dropped (grams_dropped),
        .i_ids_exhausted (ids_exhausted),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_error_count   (error_count),
        .o_outstanding   (outstanding)
    );

    // Offers one transaction and returns at the edge that accepts it. Valid stays high
    // between back-to-back transactions; it only drops when an idle gap is inserted.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch,
                             input logic eos, input logic empty);
        if (!calm && $urandom_range(99) < 26) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 26);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        char_byte  <= ch;
        end_of_str <= eos;
        empty_str  <= empty;
        do @(posedge clk); while (in_stall);
        if (cmd != kic_pkg::CMD_UNUSED) items_sent++;
    endtask

    // An alphabet size of zero means any byte; otherwise letters from 'a' on, so that
    // short strings share grams often.
    function automatic logic [7:0] pick_char(input int unsigned alpha);
        if (alpha == 0) return 8'($urandom_range(255));
        return 8'(8'h61 + $urandom_range(alpha - 1));
    endfunction

    // A string of len characters; len zero sends a whole empty string. Now and then the
    // string is closed by an empty item instead of an end mark on its last character.
    task automatic send_string(input logic [1:0] cmd, input int unsigned len,
                               input int unsigned alpha);
        bit tail_empty;
        tail_empty = ($urandom_range(9) == 0);
        if (len == 0) begin
            send_item(cmd, pick_char(0), 1'($urandom_range(1)), 1'b1);
        end else begin
            for (int unsigned i = 0; i < len; i++)
                send_item(cmd, pick_char(alpha), (i == len - 1) && !tail_empty, 1'b0);
            if (tail_empty) send_item(cmd, pick_char(0), 1'($urandom_range(1)), 1'b1);
        end
    endtask

    // Sends a slice of the recorded fill characters as one string.
    task automatic replay(input logic [1:0] cmd, input int unsigned first, input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_item(cmd, fill_chars[first + i], i == len - 1, 1'b0);
    endtask

    // Mostly well-formed index and query strings; the rest is strings whose characters pick
    // index or query at random, unused commands, clears and loose items with random flags.
    task automatic random_traffic(input int unsigned n, input int unsigned alpha,
                                  input int unsigned maxlen, input int unsigned clear_pct);
        int unsigned start;
        int unsigned r;
        int unsigned len;
        start = items_sent;
        while (items_sent - start < n) begin
            r = $urandom_range(99);
            if (r < 40) begin
                send_string(kic_pkg::CMD_INDEX, $urandom_range(maxlen), alpha);
            end else if (r < 78) begin
                send_string(kic_pkg::CMD_QUERY, $urandom_range(maxlen), alpha);
            end else if (r < 85) begin
                len = $urandom_range(maxlen, 1);
                for (int unsigned i = 0; i < len; i++)
                    send_item(($urandom_range(1) != 0) ? kic_pkg::CMD_QUERY : kic_pkg::CMD_INDEX,
                              pick_char(alpha), i == len - 1, 1'b0);
            end else if (r < 90) begin
                send_item(kic_pkg::CMD_UNUSED, pick_char(0), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end else if (r < 90 + clear_pct) begin
                send_item(kic_pkg::CMD_CLEAR, pick_char(0), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end else begin
                send_item(($urandom_range(1) != 0) ? kic_pkg::CMD_QUERY : kic_pkg::CMD_INDEX,
                          pick_char(0), 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    // Waits until every predicted result has come out, then lets the block finish any
    // scan that produces no result (a trailing character or clear).
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands on the edge where pready is seen.
    // The upper data bits are random since only the low nibble is the register.
    task automatic write_gram_length(input logic [kic_pkg::CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= GRAM_LENGTH_ADDR;
        pwdata  <= {(kic_pkg::APB_DW - kic_pkg::CFG_W)'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random stalls, except while calm, and one long hold-off once asked for.
    // During the hold the sender keeps offering, so a second finished string backs up
    // into the input channel and stalls it.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_go && !hold_done) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < 26);
        end
    end

    // Watchdog: any stretch this long without a transaction on either channel is a hang.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset gram length of three.
        send_item(kic_pkg::CMD_CLEAR, 8'h00, 1'b0, 1'b0);
        send_item(kic_pkg::CMD_INDEX, "a", 1'b0, 1'b0);
        send_item(kic_pkg::CMD_INDEX, "b", 1'b0, 1'b0);
        send_item(kic_pkg::CMD_INDEX, "c", 1'b0, 1'b0);
        send_item(kic_pkg::CMD_INDEX, "d", 1'b1, 1'b0);
        // Whole empty comparison string: takes an id, the character is ignored.
        send_item(kic_pkg::CMD_INDEX, 8'hFF, 1'b1, 1'b1);
        // Shorter than a gram: takes an id, adds nothing.
        send_item(kic_pkg::CMD_INDEX, "a", 1'b0, 1'b0);
        send_item(kic_pkg::CMD_INDEX, "b", 1'b1, 1'b0);
        send_item(kic_pkg::CMD_QUERY, "b", 1'b0, 1'b0);
        send_item(kic_pkg::CMD_QUERY, "c", 1'b0, 1'b0);
        send_item(kic_pkg::CMD_QUERY, "d", 1'b1, 1'b0);
        send_item(kic_pkg::CMD_QUERY, 8'h00, 1'b0, 1'b1);
        // The unused command must leave no trace at all.
        send_item(kic_pkg::CMD_UNUSED, 8'hFF, 1'b1, 1'b1);
        // Command switched inside a string: the query character completes the gram
        // and the end mark makes it a query result.
        send_item(kic_pkg::CMD_INDEX, "z", 1'b0, 1'b0);
        send_item(kic_pkg::CMD_INDEX, "z", 1'b0, 1'b0);
        send_item(kic_pkg::CMD_QUERY, "z", 1'b1, 1'b0);
        // Extreme character values.
        send_item(kic_pkg::CMD_INDEX, 8'h00, 1'b0, 1'b0);
        send_item(kic_pkg::CMD_INDEX, 8'hFF, 1'b0, 1'b0);
        send_item(kic_pkg::CMD_INDEX, 8'h00, 1'b1, 1'b0);
        send_item(kic_pkg::CMD_QUERY, 8'h00, 1'b0, 1'b0);
        send_item(kic_pkg::CMD_QUERY, 8'hFF, 1'b0, 1'b0);
        send_item(kic_pkg::CMD_QUERY, 8'h00, 1'b1, 1'b0);
        // A string closed by an empty item after its characters.
        send_item(kic_pkg::CMD_INDEX, "a", 1'b0, 1'b0);
        send_item(kic_pkg::CMD_INDEX, "b", 1'b0, 1'b0);
        send_item(kic_pkg::CMD_INDEX, "c", 1'b0, 1'b0);
        send_item(kic_pkg::CMD_INDEX, 8'h5A, 1'b0, 1'b1);

        // Gram length one without a clear, so old three-character keys stay in the table.
        // The long receiver hold-off happens here, with short strings and frequent results.
        settle();
        write_gram_length(4'd1);
        hold_off_go = 1'b1;
        random_traffic(40, 4, 5, 3);

        // Zero behaves as one; random bytes and no idling on either side.
        settle();
        write_gram_length(4'd0);
        calm = 1'b1;
        send_item(kic_pkg::CMD_CLEAR, 8'h00, 1'b0, 1'b0);
        random_traffic(25, 0, 5, 2);
        calm = 1'b0;

        // Two-character grams over random bytes overflow the key table. Afterwards slices
        // of the same text hit stored keys, and indexing a slice again adds its id to the
        // keys that made it in even though the table is full.
        settle();
        write_gram_length(4'd2);
        send_item(kic_pkg::CMD_CLEAR, 8'h00, 1'b0, 1'b0);
        for (int i = 0; i < FILL_LEN; i++) fill_chars[i] = pick_char(0);
        replay(kic_pkg::CMD_INDEX, 0, FILL_HALF);
        replay(kic_pkg::CMD_INDEX, FILL_HALF, FILL_LEN - FILL_HALF);
        repeat (4) replay(kic_pkg::CMD_QUERY, $urandom_range(FILL_LEN - 4), 4);
        replay(kic_pkg::CMD_INDEX, 10, 5);
        replay(kic_pkg::CMD_QUERY, 10, 3);
        random_traffic(10, 0, 6, 0);

        // Above the maximum behaves as eight. Many short comparison strings run past
        // the id capacity; queries in between see the sticky flag.
        settle();
        write_gram_length(4'd15);
        send_item(kic_pkg::CMD_CLEAR, 8'h00, 1'b0, 1'b0);
        repeat (80) begin
            if ($urandom_range(99) < 92) send_string(kic_pkg::CMD_INDEX, $urandom_range(1), 3);
            else send_string(kic_pkg::CMD_QUERY, $urandom_range(1), 3);
        end
        random_traffic(20, 2, 9, 0);

        // Full eight-character grams over a two-letter alphabet so that keys repeat.
        settle();
        write_gram_length(4'd8);
        send_item(kic_pkg::CMD_CLEAR, 8'h00, 1'b0, 1'b0);
        random_traffic(25, 2, 12, 1);

        settle();
        if (error_count == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
